@@ hdl/assert_macros.svh @@
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the label partition table.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, switched off while reset is low
`define LPT_ASSERT_IMPL(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lpt: same-cycle check failed");

// Next-cycle implication, switched off while reset is low
`define LPT_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lpt: next-cycle check failed");

`endif

@@ hdl/lpt_pkg.sv @@
// ---------------------------------------------------------------------------
// lpt_pkg
// Field widths, command codes and defaults of the label partition table.
// ---------------------------------------------------------------------------
package lpt_pkg;

  localparam int NUM_OBS_DEF    = 1024;
  localparam int NUM_LABELS_DEF = 64;

  localparam int CMD_W       = 2;
  localparam int OBS_IDX_W   = 10;
  localparam int LABEL_W     = 6;
  localparam int WEIGHT_W    = 32;
  localparam int COUNT_OUT_W = 11;
  localparam int SUM_W       = 42;
  localparam int USED_W      = 7;
  localparam int LIMIT_W     = 7;

  localparam logic [LIMIT_W-1:0]  LIMIT_RESET = 7'd64;
  localparam logic [WEIGHT_W-1:0] ONE_Q16     = 32'h0001_0000;

  localparam int CFG_ADDR_W = 1;
  localparam int CFG_DATA_W = 32;
  localparam logic [CFG_ADDR_W-1:0] ADDR_LABEL_LIMIT = 1'b0;

  typedef enum logic [CMD_W-1:0] {
    CMD_MOVE   = 2'd0,
    CMD_MERGE  = 2'd1,
    CMD_WEIGHT = 2'd2,
    CMD_QUERY  = 2'd3
  } cmd_t;

endpackage

@@ hdl/lpt_in_if.sv @@
// ---------------------------------------------------------------------------
// lpt_in_if
// Command channel: valid/ready with one command beat.
// ---------------------------------------------------------------------------
interface lpt_in_if;
  logic                          valid;
  logic                          ready;
  logic [lpt_pkg::CMD_W-1:0]     command;
  logic [lpt_pkg::OBS_IDX_W-1:0] obs_index;
  logic [lpt_pkg::LABEL_W-1:0]   label_a;
  logic [lpt_pkg::LABEL_W-1:0]   label_b;
  logic [lpt_pkg::WEIGHT_W-1:0]  weight;

  modport source (output valid, command, obs_index, label_a, label_b, weight,
                  input ready);
  modport sink   (input valid, command, obs_index, label_a, label_b, weight,
                  output ready);
endinterface

@@ hdl/lpt_out_if.sv @@
// ---------------------------------------------------------------------------
// lpt_out_if
// Result channel: valid/ready with one result beat.
// ---------------------------------------------------------------------------
interface lpt_out_if;
  logic                            valid;
  logic                            ready;
  logic [lpt_pkg::LABEL_W-1:0]     result_label;
  logic [lpt_pkg::COUNT_OUT_W-1:0] label_count;
  logic [lpt_pkg::SUM_W-1:0]       label_weight_sum;
  logic [lpt_pkg::USED_W-1:0]      used_labels;
  logic                            error;

  modport source (output valid, result_label, label_count, label_weight_sum,
                  used_labels, error, input ready);
  modport sink   (input valid, result_label, label_count, label_weight_sum,
                  used_labels, error, output ready);
endinterface

@@ hdl/lpt_ram.sv @@
// ---------------------------------------------------------------------------
// lpt_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ---------------------------------------------------------------------------
module lpt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    // hold read data between reads
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ hdl/lpt_rec_alu.sv @@
// ---------------------------------------------------------------------------
// lpt_rec_alu
// Shared add/subtract unit for a label record (member count, weight sum).
// ---------------------------------------------------------------------------
module lpt_rec_alu #(
  parameter int CNT_W = 11
) (
  input  logic                      sub,
  input  logic [CNT_W-1:0]          a_cnt,
  input  logic [lpt_pkg::SUM_W-1:0] a_sum,
  input  logic [CNT_W-1:0]          b_cnt,
  input  logic [lpt_pkg::SUM_W-1:0] b_sum,
  output logic [CNT_W-1:0]          res_cnt,
  output logic [lpt_pkg::SUM_W-1:0] res_sum
);

  // sums wrap modulo the field width
  always_comb begin
    if (sub) begin
      res_cnt = a_cnt - b_cnt;
      res_sum = a_sum - b_sum;
    end else begin
      res_cnt = a_cnt + b_cnt;
      res_sum = a_sum + b_sum;
    end
  end

endmodule

@@ hdl/label_partition_table_unit.sv @@
// ---------------------------------------------------------------------------
// label_partition_table_unit
// Partition of observations into labels: move, merge, reweight and query.
// ---------------------------------------------------------------------------
// channel  | direction | beat
// in_if    | sink      | command, obs_index, label_a, label_b, weight
// out_if   | source    | result_label, label_count, label_weight_sum,
//          |           | used_labels, error
// cfg_*    | APB slave | label_limit at byte address 0
//
// Per command, accept to result: a query reads the observation RAM, then
// the label RAM; move and weight write then write the records back; a
// rejected command goes straight to the result; a merge of a label with
// itself reads its record; other merges scan every observation once, then
// update both records. The next command is taken once the result is in the
// output register. One observation RAM read port and one shared record adder
// for label RAM read-modify-writes set this order. After reset a clearing pass
// over max(NUM_OBS, label depth) entries fills the RAMs, taking no command.
// A result waits in the output register while the next command is taken.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module label_partition_table_unit #(
  parameter int NUM_OBS    = lpt_pkg::NUM_OBS_DEF,
  parameter int NUM_LABELS = lpt_pkg::NUM_LABELS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  lpt_in_if.sink                         in_if,
  lpt_out_if.source                      out_if,
  input  logic                           cfg_psel,
  input  logic                           cfg_penable,
  input  logic                           cfg_pwrite,
  input  logic [lpt_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [lpt_pkg::CFG_DATA_W-1:0] cfg_pwdata,
  output logic [lpt_pkg::CFG_DATA_W-1:0] cfg_prdata,
  output logic                           cfg_pready
);

  localparam int LABEL_W  = lpt_pkg::LABEL_W;
  localparam int WEIGHT_W = lpt_pkg::WEIGHT_W;
  localparam int SUM_W    = lpt_pkg::SUM_W;
  localparam int USED_W   = lpt_pkg::USED_W;
  localparam int LDEPTH   = (NUM_LABELS < (1 << LABEL_W)) ? NUM_LABELS : (1 << LABEL_W);
  localparam int LIDX_W   = $clog2(LDEPTH);
  localparam int OIDX_W   = $clog2(NUM_OBS);
  localparam int CNT_W    = $clog2(NUM_OBS + 1);
  localparam int SCAN_W   = OIDX_W + 1;
  localparam int CLR_LEN  = (NUM_OBS > LDEPTH) ? NUM_OBS : LDEPTH;
  localparam int CLR_W    = $clog2(CLR_LEN + 1);
  localparam int OBS_RW   = LABEL_W + WEIGHT_W;
  localparam int LAB_RW   = CNT_W + SUM_W;
  localparam logic [CNT_W-1:0] RESET_CNT = CNT_W'(NUM_OBS);
  localparam logic [SUM_W-1:0] RESET_SUM = SUM_W'(64'(NUM_OBS) << 16);

  typedef enum logic [10:0] {
    ST_CLR   = 11'b000_0000_0001,
    ST_IDLE  = 11'b000_0000_0010,
    ST_LAB1  = 11'b000_0000_0100,
    ST_FROM  = 11'b000_0000_1000,
    ST_TO    = 11'b000_0001_0000,
    ST_WADD  = 11'b000_0010_0000,
    ST_SCAN  = 11'b000_0100_0000,
    ST_MORIG = 11'b000_1000_0000,
    ST_MDEST = 11'b001_0000_0000,
    ST_MSELF = 11'b010_0000_0000,
    ST_OUT   = 11'b100_0000_0000
  } state_t;

  state_t                        state_r, state_nxt;
  lpt_pkg::cmd_t                 cmd_r, cmd_nxt;
  logic [OIDX_W-1:0]             n_r, n_nxt;
  logic [LABEL_W-1:0]            dest_r, dest_nxt;
  logic [LABEL_W-1:0]            orig_r, orig_nxt;
  logic [WEIGHT_W-1:0]           w_r, w_nxt;
  logic [LABEL_W-1:0]            from_r, from_nxt;
  logic [WEIGHT_W-1:0]           oldw_r, oldw_nxt;
  logic [CNT_W-1:0]              tmp_cnt_r, tmp_cnt_nxt;
  logic [SUM_W-1:0]              tmp_sum_r, tmp_sum_nxt;
  logic [CNT_W-1:0]              acc_cnt_r, acc_cnt_nxt;
  logic [SUM_W-1:0]              acc_sum_r, acc_sum_nxt;
  logic [SCAN_W-1:0]             scan_idx_r, scan_idx_nxt;
  logic [OIDX_W-1:0]             rd_idx_r, rd_idx_nxt;
  logic                          rd_vld_r, rd_vld_nxt;
  logic [CLR_W-1:0]              clr_idx_r, clr_idx_nxt;
  logic [USED_W-1:0]             used_total_r, used_total_nxt;
  logic [lpt_pkg::LIMIT_W-1:0]   limit_r, limit_nxt;
  logic [LABEL_W-1:0]            pend_label_r, pend_label_nxt;
  logic [CNT_W-1:0]              pend_cnt_r, pend_cnt_nxt;
  logic [SUM_W-1:0]              pend_sum_r, pend_sum_nxt;
  logic                          pend_err_r, pend_err_nxt;
  logic                          out_valid_r, out_valid_nxt;
  logic [LABEL_W-1:0]            out_label_r, out_label_nxt;
  logic [lpt_pkg::COUNT_OUT_W-1:0] out_cnt_r, out_cnt_nxt;
  logic [SUM_W-1:0]              out_sum_r, out_sum_nxt;
  logic [USED_W-1:0]             out_used_r, out_used_nxt;
  logic                          out_err_r, out_err_nxt;

  logic                  obs_we, obs_re;
  logic [OIDX_W-1:0]     obs_waddr, obs_raddr;
  logic [OBS_RW-1:0]     obs_wdata, obs_rdata;
  logic                  lab_we, lab_re;
  logic [LIDX_W-1:0]     lab_waddr, lab_raddr;
  logic [LAB_RW-1:0]     lab_wdata, lab_rdata;
  logic [LABEL_W-1:0]    obs_rd_label;
  logic [WEIGHT_W-1:0]   obs_rd_w;
  logic [CNT_W-1:0]      lab_rd_cnt;
  logic [SUM_W-1:0]      lab_rd_sum;

  logic                  alu_sub;
  logic [CNT_W-1:0]      alu_a_cnt, alu_b_cnt, alu_res_cnt;
  logic [SUM_W-1:0]      alu_a_sum, alu_b_sum, alu_res_sum;

  logic                  accept, cfg_we;
  lpt_pkg::cmd_t         in_cmd;
  logic                  la_bad, lb_bad, obs_bad;
  logic [LABEL_W-1:0]    merge_lo, merge_hi;

  lpt_ram #(.WIDTH(OBS_RW), .DEPTH(NUM_OBS)) u_obs_ram (
    .clk   (clk),
    .we    (obs_we),
    .waddr (obs_waddr),
    .wdata (obs_wdata),
    .re    (obs_re),
    .raddr (obs_raddr),
    .rdata (obs_rdata)
  );

  lpt_ram #(.WIDTH(LAB_RW), .DEPTH(LDEPTH)) u_lab_ram (
    .clk   (clk),
    .we    (lab_we),
    .waddr (lab_waddr),
    .wdata (lab_wdata),
    .re    (lab_re),
    .raddr (lab_raddr),
    .rdata (lab_rdata)
  );

  lpt_rec_alu #(.CNT_W(CNT_W)) u_alu (
    .sub     (alu_sub),
    .a_cnt   (alu_a_cnt),
    .a_sum   (alu_a_sum),
    .b_cnt   (alu_b_cnt),
    .b_sum   (alu_b_sum),
    .res_cnt (alu_res_cnt),
    .res_sum (alu_res_sum)
  );

  assign obs_rd_label = obs_rdata[OBS_RW-1 -: LABEL_W];
  assign obs_rd_w     = obs_rdata[WEIGHT_W-1:0];
  assign lab_rd_cnt   = lab_rdata[LAB_RW-1 -: CNT_W];
  assign lab_rd_sum   = lab_rdata[SUM_W-1:0];

  // configuration port
  assign cfg_pready = 1'b1;
  assign cfg_we     = cfg_psel && cfg_penable && cfg_pwrite &&
                      (cfg_paddr == lpt_pkg::ADDR_LABEL_LIMIT);
  assign limit_nxt  = cfg_we ? cfg_pwdata[lpt_pkg::LIMIT_W-1:0] : limit_r;
  assign cfg_prdata = (cfg_paddr == lpt_pkg::ADDR_LABEL_LIMIT) ?
                      lpt_pkg::CFG_DATA_W'(limit_r) : '0;

  // command decode
  assign in_if.ready = (state_r == ST_IDLE);
  assign accept      = in_if.valid && in_if.ready;
  assign in_cmd      = lpt_pkg::cmd_t'(in_if.command);
  assign la_bad      = ({1'b0, in_if.label_a} >= limit_r) || (32'(in_if.label_a) >= NUM_LABELS);
  assign lb_bad      = ({1'b0, in_if.label_b} >= limit_r) || (32'(in_if.label_b) >= NUM_LABELS);
  assign obs_bad     = 32'(in_if.obs_index) >= NUM_OBS;
  assign merge_lo    = (in_if.label_a < in_if.label_b) ? in_if.label_a : in_if.label_b;
  assign merge_hi    = (in_if.label_a < in_if.label_b) ? in_if.label_b : in_if.label_a;

  assign out_if.valid            = out_valid_r;
  assign out_if.result_label     = out_label_r;
  assign out_if.label_count      = out_cnt_r;
  assign out_if.label_weight_sum = out_sum_r;
  assign out_if.used_labels      = out_used_r;
  assign out_if.error            = out_err_r;

  always_comb begin
    state_nxt      = state_r;
    cmd_nxt        = cmd_r;
    n_nxt          = n_r;
    dest_nxt       = dest_r;
    orig_nxt       = orig_r;
    w_nxt          = w_r;
    from_nxt       = from_r;
    oldw_nxt       = oldw_r;
    tmp_cnt_nxt    = tmp_cnt_r;
    tmp_sum_nxt    = tmp_sum_r;
    acc_cnt_nxt    = acc_cnt_r;
    acc_sum_nxt    = acc_sum_r;
    scan_idx_nxt   = scan_idx_r;
    rd_idx_nxt     = rd_idx_r;
    rd_vld_nxt     = rd_vld_r;
    clr_idx_nxt    = clr_idx_r;
    used_total_nxt = used_total_r;
    pend_label_nxt = pend_label_r;
    pend_cnt_nxt   = pend_cnt_r;
    pend_sum_nxt   = pend_sum_r;
    pend_err_nxt   = pend_err_r;
    out_valid_nxt  = out_valid_r && !out_if.ready;
    out_label_nxt  = out_label_r;
    out_cnt_nxt    = out_cnt_r;
    out_sum_nxt    = out_sum_r;
    out_used_nxt   = out_used_r;
    out_err_nxt    = out_err_r;

    obs_we    = 1'b0;
    obs_waddr = n_r;
    obs_wdata = {dest_r, oldw_r};
    obs_re    = 1'b0;
    obs_raddr = n_r;
    lab_we    = 1'b0;
    lab_waddr = LIDX_W'(from_r);
    lab_wdata = {alu_res_cnt, alu_res_sum};
    lab_re    = 1'b0;
    lab_raddr = LIDX_W'(dest_r);

    alu_sub   = 1'b0;
    alu_a_cnt = lab_rd_cnt;
    alu_a_sum = lab_rd_sum;
    alu_b_cnt = '0;
    alu_b_sum = SUM_W'(oldw_r);

    case (state_r)
      ST_CLR: begin
        if (clr_idx_r < CLR_W'(NUM_OBS)) begin
          obs_we    = 1'b1;
          obs_waddr = OIDX_W'(clr_idx_r);
          obs_wdata = {{LABEL_W{1'b0}}, lpt_pkg::ONE_Q16};
        end
        if (clr_idx_r < CLR_W'(LDEPTH)) begin
          lab_we    = 1'b1;
          lab_waddr = LIDX_W'(clr_idx_r);
          lab_wdata = (clr_idx_r == '0) ? {RESET_CNT, RESET_SUM} : '0;
        end
        clr_idx_nxt = clr_idx_r + CLR_W'(1);
        if (clr_idx_r == CLR_W'(CLR_LEN - 1)) begin
          state_nxt = ST_IDLE;
        end
      end

      ST_IDLE: begin
        if (accept) begin
          cmd_nxt = in_cmd;
          n_nxt   = OIDX_W'(in_if.obs_index);
          w_nxt   = in_if.weight;
          if (in_cmd == lpt_pkg::CMD_MERGE) begin
            dest_nxt = merge_lo;
            orig_nxt = merge_hi;
            if (la_bad || lb_bad) begin
              pend_label_nxt = '0;
              pend_cnt_nxt   = '0;
              pend_sum_nxt   = '0;
              pend_err_nxt   = 1'b1;
              state_nxt      = ST_OUT;
            end else if (merge_lo == merge_hi) begin
              lab_re    = 1'b1;
              lab_raddr = LIDX_W'(merge_lo);
              state_nxt = ST_MSELF;
            end else begin
              scan_idx_nxt = '0;
              rd_vld_nxt   = 1'b0;
              acc_cnt_nxt  = '0;
              acc_sum_nxt  = '0;
              state_nxt    = ST_SCAN;
            end
          end else if (obs_bad || (in_cmd == lpt_pkg::CMD_MOVE && la_bad)) begin
            pend_label_nxt = '0;
            pend_cnt_nxt   = '0;
            pend_sum_nxt   = '0;
            pend_err_nxt   = 1'b1;
            state_nxt      = ST_OUT;
          end else begin
            dest_nxt  = in_if.label_a;
            obs_re    = 1'b1;
            obs_raddr = OIDX_W'(in_if.obs_index);
            state_nxt = ST_LAB1;
          end
        end
      end

      ST_LAB1: begin
        from_nxt  = obs_rd_label;
        oldw_nxt  = obs_rd_w;
        lab_re    = 1'b1;
        lab_raddr = LIDX_W'(obs_rd_label);
        state_nxt = ST_FROM;
      end

      ST_FROM: begin
        pend_label_nxt = from_r;
        pend_cnt_nxt   = lab_rd_cnt;
        pend_sum_nxt   = lab_rd_sum;
        pend_err_nxt   = 1'b0;
        state_nxt      = ST_OUT;
        case (cmd_r)
          lpt_pkg::CMD_MOVE: begin
            if (from_r != dest_r) begin
              // take the member out of its old label
              alu_sub   = 1'b1;
              alu_b_cnt = CNT_W'(1);
              lab_we    = 1'b1;
              lab_waddr = LIDX_W'(from_r);
              if (alu_res_cnt == '0) begin
                used_total_nxt = used_total_r - USED_W'(1);
              end
              lab_re    = 1'b1;
              lab_raddr = LIDX_W'(dest_r);
              state_nxt = ST_TO;
            end
          end
          lpt_pkg::CMD_WEIGHT: begin
            alu_sub     = 1'b1;
            tmp_cnt_nxt = lab_rd_cnt;
            tmp_sum_nxt = alu_res_sum;
            state_nxt   = ST_WADD;
          end
          default: begin
          end
        endcase
      end

      ST_TO: begin
        alu_b_cnt = CNT_W'(1);
        lab_we    = 1'b1;
        lab_waddr = LIDX_W'(dest_r);
        if (lab_rd_cnt == '0) begin
          used_total_nxt = used_total_r + USED_W'(1);
        end
        obs_we         = 1'b1;
        obs_wdata      = {dest_r, oldw_r};
        pend_label_nxt = dest_r;
        pend_cnt_nxt   = alu_res_cnt;
        pend_sum_nxt   = alu_res_sum;
        pend_err_nxt   = 1'b0;
        state_nxt      = ST_OUT;
      end

      ST_WADD: begin
        alu_a_cnt      = tmp_cnt_r;
        alu_a_sum      = tmp_sum_r;
        alu_b_sum      = SUM_W'(w_r);
        lab_we         = 1'b1;
        lab_waddr      = LIDX_W'(from_r);
        obs_we         = 1'b1;
        obs_wdata      = {from_r, w_r};
        pend_label_nxt = from_r;
        pend_cnt_nxt   = tmp_cnt_r;
        pend_sum_nxt   = alu_res_sum;
        pend_err_nxt   = 1'b0;
        state_nxt      = ST_OUT;
      end

      ST_SCAN: begin
        // relabel members of the higher label and total what moves
        alu_a_cnt = acc_cnt_r;
        alu_a_sum = acc_sum_r;
        alu_b_cnt = CNT_W'(1);
        alu_b_sum = SUM_W'(obs_rd_w);
        if (rd_vld_r && obs_rd_label == orig_r) begin
          obs_we      = 1'b1;
          obs_waddr   = rd_idx_r;
          obs_wdata   = {dest_r, obs_rd_w};
          acc_cnt_nxt = alu_res_cnt;
          acc_sum_nxt = alu_res_sum;
        end
        if (scan_idx_r != SCAN_W'(NUM_OBS)) begin
          obs_re       = 1'b1;
          obs_raddr    = scan_idx_r[OIDX_W-1:0];
          rd_idx_nxt   = scan_idx_r[OIDX_W-1:0];
          rd_vld_nxt   = 1'b1;
          scan_idx_nxt = scan_idx_r + SCAN_W'(1);
        end else begin
          rd_vld_nxt = 1'b0;
          lab_re     = 1'b1;
          lab_raddr  = LIDX_W'(orig_r);
          state_nxt  = ST_MORIG;
        end
      end

      ST_MORIG: begin
        alu_sub   = 1'b1;
        alu_b_cnt = acc_cnt_r;
        alu_b_sum = acc_sum_r;
        lab_we    = 1'b1;
        lab_waddr = LIDX_W'(orig_r);
        if (acc_cnt_r != '0 && alu_res_cnt == '0) begin
          used_total_nxt = used_total_r - USED_W'(1);
        end
        lab_re    = 1'b1;
        lab_raddr = LIDX_W'(dest_r);
        state_nxt = ST_MDEST;
      end

      ST_MDEST: begin
        alu_b_cnt = acc_cnt_r;
        alu_b_sum = acc_sum_r;
        lab_we    = 1'b1;
        lab_waddr = LIDX_W'(dest_r);
        if (acc_cnt_r != '0 && lab_rd_cnt == '0) begin
          used_total_nxt = used_total_r + USED_W'(1);
        end
        pend_label_nxt = dest_r;
        pend_cnt_nxt   = alu_res_cnt;
        pend_sum_nxt   = alu_res_sum;
        pend_err_nxt   = 1'b0;
        state_nxt      = ST_OUT;
      end

      ST_MSELF: begin
        pend_label_nxt = dest_r;
        pend_cnt_nxt   = lab_rd_cnt;
        pend_sum_nxt   = lab_rd_sum;
        pend_err_nxt   = 1'b0;
        state_nxt      = ST_OUT;
      end

      ST_OUT: begin
        // hold until the output register is free
        if (!out_valid_r || out_if.ready) begin
          out_valid_nxt = 1'b1;
          out_label_nxt = pend_label_r;
          out_cnt_nxt   = lpt_pkg::COUNT_OUT_W'(pend_cnt_r);
          out_sum_nxt   = pend_sum_r;
          out_used_nxt  = used_total_r;
          out_err_nxt   = pend_err_r;
          state_nxt     = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_CLR;
      clr_idx_r    <= '0;
      rd_vld_r     <= 1'b0;
      used_total_r <= USED_W'(1);
      limit_r      <= lpt_pkg::LIMIT_RESET;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      clr_idx_r    <= clr_idx_nxt;
      rd_vld_r     <= rd_vld_nxt;
      used_total_r <= used_total_nxt;
      limit_r      <= limit_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r        <= cmd_nxt;
    n_r          <= n_nxt;
    dest_r       <= dest_nxt;
    orig_r       <= orig_nxt;
    w_r          <= w_nxt;
    from_r       <= from_nxt;
    oldw_r       <= oldw_nxt;
    tmp_cnt_r    <= tmp_cnt_nxt;
    tmp_sum_r    <= tmp_sum_nxt;
    acc_cnt_r    <= acc_cnt_nxt;
    acc_sum_r    <= acc_sum_nxt;
    scan_idx_r   <= scan_idx_nxt;
    rd_idx_r     <= rd_idx_nxt;
    pend_label_r <= pend_label_nxt;
    pend_cnt_r   <= pend_cnt_nxt;
    pend_sum_r   <= pend_sum_nxt;
    pend_err_r   <= pend_err_nxt;
    out_label_r  <= out_label_nxt;
    out_cnt_r    <= out_cnt_nxt;
    out_sum_r    <= out_sum_nxt;
    out_used_r   <= out_used_nxt;
    out_err_r    <= out_err_nxt;
  end

  `LPT_ASSERT_IMPL(a_used_range, clk, rst_n, 1'b1, used_total_r != '0 && used_total_r <= USED_W'(LDEPTH))
  `LPT_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_if.valid && in_if.ready, !in_if.ready)
  `LPT_ASSERT_IMPL(a_obs_rw_apart, clk, rst_n, obs_we && obs_re, obs_waddr != obs_raddr)
  `LPT_ASSERT_IMPL(a_lab_rw_apart, clk, rst_n, lab_we && lab_re, lab_waddr != lab_raddr)

endmodule

@@ dv/tb_label_partition_table_unit.sv @@
// ---------------------------------------------------------------------------
// tb_label_partition_table_unit
// Self-checking bench for the label partition table. A short directed table
// covers reset contents, field extremes, every command, merges of a label
// with itself, moves to the current label, rejected labels and labels left
// above a lowered limit. Random traffic follows over several limit settings.
// A local model of the label, weight, count and sum stores predicts each
// result beat the table leaves open; each beat is compared field by field.
// ---------------------------------------------------------------------------
module tb_label_partition_table_unit;
  import lpt_pkg::*;

  localparam int NOBS = NUM_OBS_DEF;
  localparam int NLAB = NUM_LABELS_DEF;
  localparam logic [SUM_W-1:0] SUM_RST = 42'd67108864;
  localparam int N_DIR = 27;
  localparam int PHASE_ITEMS = 200;
  // a zero entry picks a random limit
  localparam int PHASE_LIMITS [8] = '{64, 1, 64, 2, 37, 64, 0, 0};

  typedef struct packed {
    cmd_t                 cmd;
    logic [OBS_IDX_W-1:0] obs;
    logic [LABEL_W-1:0]   la;
    logic [LABEL_W-1:0]   lb;
    logic [WEIGHT_W-1:0]  wt;
  } lpt_cmd_t;

  typedef struct packed {
    logic [LABEL_W-1:0]     lab;
    logic [COUNT_OUT_W-1:0] count;
    logic [SUM_W-1:0]       wsum;
    logic [USED_W-1:0]      used;
    logic                   err;
  } lpt_res_t;

  typedef struct packed {
    logic               cfg;
    logic [LIMIT_W-1:0] lim;
    lpt_cmd_t           req;
    logic               typed;
    lpt_res_t           res;
  } dir_row_t;

  localparam lpt_cmd_t NO_REQ = '{CMD_QUERY, '0, '0, '0, '0};
  localparam lpt_res_t NO_RES = '0;
  localparam lpt_res_t AT_RESET = '{6'd0, 11'd1024, SUM_RST, 7'd1, 1'b0};
  localparam lpt_res_t REJ_USED1 = '{6'd0, 11'd0, 42'd0, 7'd1, 1'b1};
  localparam lpt_res_t REJ_USED2 = '{6'd0, 11'd0, 42'd0, 7'd2, 1'b1};

  dir_row_t directed_rows [N_DIR] = '{
    '{0, 7'd0, '{CMD_QUERY, 10'd0, 6'd0, 6'd0, 32'd0}, 1, AT_RESET},
    '{0, 7'd0, '{CMD_QUERY, 10'd1023, 6'd63, 6'd63, 32'hFFFF_FFFF}, 1, AT_RESET},
    '{0, 7'd0, '{CMD_MOVE, 10'd1023, 6'd63, 6'd0, 32'd0}, 1,
      '{6'd63, 11'd1, 42'd65536, 7'd2, 1'b0}},
    '{0, 7'd0, '{CMD_MOVE, 10'd0, 6'd0, 6'd63, 32'hFFFF_FFFF}, 1,
      '{6'd0, 11'd1023, 42'd67043328, 7'd2, 1'b0}},
    '{0, 7'd0, '{CMD_WEIGHT, 10'd1023, 6'd0, 6'd0, 32'hFFFF_FFFF}, 1,
      '{6'd63, 11'd1, 42'hFFFF_FFFF, 7'd2, 1'b0}},
    '{0, 7'd0, '{CMD_WEIGHT, 10'd0, 6'd63, 6'd63, 32'd0}, 0, NO_RES},
    '{0, 7'd0, '{CMD_MOVE, 10'd1, 6'd62, 6'd0, 32'd0}, 0, NO_RES},
    '{0, 7'd0, '{CMD_MERGE, 10'd0, 6'd63, 6'd63, 32'd0}, 1,
      '{6'd63, 11'd1, 42'hFFFF_FFFF, 7'd3, 1'b0}},
    '{0, 7'd0, '{CMD_MERGE, 10'd1023, 6'd63, 6'd62, 32'hFFFF_FFFF}, 0, NO_RES},
    '{0, 7'd0, '{CMD_MERGE, 10'd0, 6'd0, 6'd62, 32'd0}, 0, NO_RES},
    '{0, 7'd0, '{CMD_MOVE, 10'd100, 6'd50, 6'd0, 32'd0}, 0, NO_RES},
    '{0, 7'd0, '{CMD_MOVE, 10'd101, 6'd50, 6'd0, 32'd0}, 0, NO_RES},
    '{1, 7'd8, NO_REQ, 0, NO_RES},
    '{0, 7'd0, '{CMD_MOVE, 10'd200, 6'd8, 6'd0, 32'd0}, 1, REJ_USED2},
    '{0, 7'd0, '{CMD_MERGE, 10'd0, 6'd7, 6'd8, 32'd0}, 1, REJ_USED2},
    '{0, 7'd0, '{CMD_MERGE, 10'd0, 6'd63, 6'd0, 32'd0}, 1, REJ_USED2},
    '{0, 7'd0, '{CMD_QUERY, 10'd100, 6'd0, 6'd0, 32'd0}, 0, NO_RES},
    '{0, 7'd0, '{CMD_WEIGHT, 10'd101, 6'd0, 6'd0, 32'h1234_5678}, 0, NO_RES},
    '{0, 7'd0, '{CMD_MOVE, 10'd100, 6'd7, 6'd0, 32'd0}, 0, NO_RES},
    '{0, 7'd0, '{CMD_MERGE, 10'd0, 6'd7, 6'd0, 32'd0}, 0, NO_RES},
    '{1, 7'd1, NO_REQ, 0, NO_RES},
    '{0, 7'd0, '{CMD_MOVE, 10'd3, 6'd1, 6'd0, 32'd0}, 1, REJ_USED2},
    '{0, 7'd0, '{CMD_MOVE, 10'd101, 6'd0, 6'd0, 32'd0}, 0, NO_RES},
    '{0, 7'd0, '{CMD_MERGE, 10'd0, 6'd0, 6'd0, 32'd0}, 0, NO_RES},
    '{0, 7'd0, '{CMD_MERGE, 10'd0, 6'd0, 6'd1, 32'd0}, 1, REJ_USED1},
    '{1, 7'd64, NO_REQ, 0, NO_RES},
    '{0, 7'd0, '{CMD_MOVE, 10'd5, 6'd63, 6'd0, 32'd0}, 0, NO_RES}
  };

  logic clk = 1'b0;
  logic rst_n;
  logic                  cfg_psel;
  logic                  cfg_penable;
  logic                  cfg_pwrite;
  logic [CFG_ADDR_W-1:0] cfg_paddr;
  logic [CFG_DATA_W-1:0] cfg_pwdata;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  lpt_in_if  in_bus ();
  lpt_out_if out_bus ();

  label_partition_table_unit DUT (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_if       (in_bus),
    .out_if      (out_bus),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always #5 clk = ~clk;

  // model of the partition
  logic [LABEL_W-1:0]     obs_label_m  [NOBS];
  logic [WEIGHT_W-1:0]    obs_weight_m [NOBS];
  logic [COUNT_OUT_W-1:0] count_m      [NLAB];
  logic [SUM_W-1:0]       wsum_m       [NLAB];
  int                     used_m;
  logic [LIMIT_W-1:0]     limit_m;

  lpt_res_t pending_results [$];
  lpt_res_t want_res;
  int       mismatch_count = 0;
  int       out_beats = 0;
  int       burst_left = 0;
  bit       no_gaps = 0;

  function automatic int eff_limit();
    return (limit_m < NLAB) ? int'(limit_m) : NLAB;
  endfunction

  function automatic void relabel_obs(int n, logic [LABEL_W-1:0] to);
    logic [LABEL_W-1:0] from;
    logic [SUM_W-1:0]   w;
    from = obs_label_m[n];
    w    = SUM_W'(obs_weight_m[n]);
    if (from == to) return;
    count_m[from]--;
    wsum_m[from] = wsum_m[from] - w;
    if (count_m[from] == 0) used_m--;
    if (count_m[to] == 0) used_m++;
    count_m[to]++;
    wsum_m[to] = wsum_m[to] + w;
    obs_label_m[n] = to;
  endfunction

  function automatic lpt_res_t apply_command(lpt_cmd_t c);
    int                 eff;
    logic [LABEL_W-1:0] dest;
    logic [LABEL_W-1:0] orig;
    logic [LABEL_W-1:0] lab;
    lpt_res_t           r;
    eff    = eff_limit();
    r      = '0;
    r.used = USED_W'(used_m);
    if (c.cmd == CMD_MERGE) begin
      if (c.la >= eff || c.lb >= eff) begin
        r.err = 1'b1;
        return r;
      end
      dest = (c.la < c.lb) ? c.la : c.lb;
      orig = (c.la < c.lb) ? c.lb : c.la;
      if (dest != orig) begin
        for (int i = 0; i < NOBS; i++)
          if (obs_label_m[i] == orig) relabel_obs(i, dest);
      end
      lab = dest;
    end else begin
      if (c.cmd == CMD_MOVE) begin
        if (c.la >= eff) begin
          r.err = 1'b1;
          return r;
        end
        relabel_obs(c.obs, c.la);
      end else if (c.cmd == CMD_WEIGHT) begin
        lab = obs_label_m[c.obs];
        wsum_m[lab] = wsum_m[lab] - SUM_W'(obs_weight_m[c.obs]) + SUM_W'(c.wt);
        obs_weight_m[c.obs] = c.wt;
      end
      lab = obs_label_m[c.obs];
    end
    r.lab   = lab;
    r.count = count_m[lab];
    r.wsum  = wsum_m[lab];
    r.used  = USED_W'(used_m);
    return r;
  endfunction

  // lean towards the low labels so merges find members
  function automatic logic [LABEL_W-1:0] pick_label(int eff);
    case ($urandom_range(0, 9))
      0, 1, 2: return LABEL_W'($urandom_range(0, ((eff < 8) ? eff : 8) - 1));
      3, 4, 5: return LABEL_W'($urandom_range(0, eff - 1));
      6, 7:    return LABEL_W'($urandom_range(0, NLAB - 1));
      8:       return LABEL_W'(eff - 1);
      default: return LABEL_W'((eff >= NLAB) ? NLAB - 1 : eff);
    endcase
  endfunction

  function automatic lpt_cmd_t random_command(int eff);
    lpt_cmd_t c;
    int       pick;
    c.obs = OBS_IDX_W'($urandom);
    c.la  = pick_label(eff);
    c.lb  = pick_label(eff);
    case ($urandom_range(0, 7))
      0:       c.wt = '0;
      1:       c.wt = '1;
      2:       c.wt = ONE_Q16;
      default: c.wt = $urandom;
    endcase
    pick = $urandom_range(0, 99);
    if (pick < 8) begin
      // noise: any command with raw label fields
      c.cmd = cmd_t'($urandom_range(0, 3));
      c.la  = LABEL_W'($urandom);
      c.lb  = LABEL_W'($urandom);
    end else if (pick < 46) c.cmd = CMD_MOVE;
    else if (pick < 66)     c.cmd = CMD_WEIGHT;
    else if (pick < 90)     c.cmd = CMD_QUERY;
    else                    c.cmd = CMD_MERGE;
    return c;
  endfunction

  task automatic check_field(input string what, input logic [63:0] want,
                             input logic [63:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch: expected 0x%0h, got 0x%0h", $time, what, want, got);
      mismatch_count++;
    end
  endtask

  task automatic issue_command(input lpt_cmd_t c, input logic typed, input lpt_res_t res);
    int gap;
    if (burst_left == 0) begin
      gap = no_gaps ? 0 : $urandom_range(0, 8);
      if (gap > 0) begin
        @(negedge clk);
        in_bus.valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    @(negedge clk);
    in_bus.valid     <= 1'b1;
    in_bus.command   <= c.cmd;
    in_bus.obs_index <= c.obs;
    in_bus.label_a   <= c.la;
    in_bus.label_b   <= c.lb;
    in_bus.weight    <= c.wt;
    do @(posedge clk); while (!in_bus.ready);
    want_res = apply_command(c);
    pending_results.push_back(typed ? res : want_res);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_bus.valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
  endtask

  task automatic apb_xfer(input logic wr, input logic [CFG_DATA_W-1:0] wdata,
                          output logic [CFG_DATA_W-1:0] rdata);
    @(negedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= wr;
    cfg_paddr   <= ADDR_LABEL_LIMIT;
    cfg_pwdata  <= wdata;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    rdata = cfg_prdata;
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
  endtask

  task automatic set_label_limit(input logic [LIMIT_W-1:0] v);
    logic [CFG_DATA_W-1:0] rd;
    wait_drained();
    repeat (4) @(negedge clk);
    apb_xfer(1'b1, CFG_DATA_W'(v), rd);
    apb_xfer(1'b0, '0, rd);
    check_field("label_limit readback", v, rd[LIMIT_W-1:0]);
    limit_m = v;
  endtask

  // result beat checker
  always @(posedge clk) begin
    if (rst_n && out_bus.valid && out_bus.ready) begin
      out_beats++;
      if (pending_results.size() == 0) begin
        $display("%0t: result beat with nothing expected: label %0d", $time,
                 out_bus.result_label);
        mismatch_count++;
      end else begin
        want_res = pending_results.pop_front();
        check_field("result_label", want_res.lab, out_bus.result_label);
        check_field("label_count", want_res.count, out_bus.label_count);
        check_field("label_weight_sum", want_res.wsum, out_bus.label_weight_sum);
        check_field("used_labels", want_res.used, out_bus.used_labels);
        check_field("error", want_res.err, out_bus.error);
      end
    end
  end

  // receiver: stall modes of its own, plus one long hold-off
  initial begin : receiver
    int         mode;
    int         mode_left;
    logic [7:0] pat;
    bit         held;
    mode      = 0;
    mode_left = 0;
    pat       = '1;
    held      = 0;
    forever begin
      @(negedge clk);
      if (!held && out_beats >= 300) begin
        // hold off so the result register fills and the input backs up
        out_bus.ready <= 1'b0;
        repeat (500) @(negedge clk);
        held = 1;
      end else begin
        if (mode_left == 0) begin
          mode      = $urandom_range(0, 2);
          mode_left = $urandom_range(16, 96);
          pat       = 8'($urandom) | 8'h01;
        end
        mode_left--;
        case (mode)
          0:       out_bus.ready <= 1'b1;
          1:       out_bus.ready <= ($urandom_range(0, 3) != 0);
          default: begin
            out_bus.ready <= pat[0];
            pat = {pat[0], pat[7:1]};
          end
        endcase
      end
    end
  end

  initial begin : stimulus
    int lim;
    rst_n            = 1'b0;
    in_bus.valid     = 1'b0;
    in_bus.command   = CMD_MOVE;
    in_bus.obs_index = '0;
    in_bus.label_a   = '0;
    in_bus.label_b   = '0;
    in_bus.weight    = '0;
    out_bus.ready    = 1'b0;
    cfg_psel         = 1'b0;
    cfg_penable      = 1'b0;
    cfg_pwrite       = 1'b0;
    cfg_paddr        = '0;
    cfg_pwdata       = '0;
    for (int i = 0; i < NOBS; i++) begin
      obs_label_m[i]  = '0;
      obs_weight_m[i] = ONE_Q16;
    end
    for (int i = 0; i < NLAB; i++) begin
      count_m[i] = '0;
      wsum_m[i]  = '0;
    end
    count_m[0] = COUNT_OUT_W'(NOBS);
    wsum_m[0]  = SUM_RST;
    used_m     = 1;
    limit_m    = LIMIT_RESET;

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i]) begin
      if (directed_rows[i].cfg)
        set_label_limit(directed_rows[i].lim);
      else
        issue_command(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].res);
    end

    foreach (PHASE_LIMITS[p]) begin
      lim = (PHASE_LIMITS[p] != 0) ? PHASE_LIMITS[p] : $urandom_range(1, NLAB);
      set_label_limit(LIMIT_W'(lim));
      no_gaps = (p == 2);
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        // pause the sender until the block has drained
        if (k == PHASE_ITEMS / 2) wait_drained();
        issue_command(random_command(eff_limit()), 1'b0, NO_RES);
      end
    end

    wait_drained();
    repeat (32) @(negedge clk);
    if (mismatch_count == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin : watchdog
    #60_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
